>>> hdl/utf16be_to_utf8_escaper_macros.svh
// ----------------------------------------------------------------------------
// utf16be_to_utf8_escaper assertion macros
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef UTF16BE_TO_UTF8_ESCAPER_MACROS_SVH
`define UTF16BE_TO_UTF8_ESCAPER_MACROS_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Condition must never be true.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("assertion failed: forbidden condition");

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`define ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

>>> hdl/ute_pkg.sv
// ----------------------------------------------------------------------------
// ute_pkg
// Types, constants and helpers shared by the UTF-16 to escaped UTF-8 blocks.
// ----------------------------------------------------------------------------
package ute_pkg;

    // Configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_UTF8   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDENT_SPACES = 2'd1;
    localparam logic [3:0]           INDENT_RESET      = 4'd6;

    // Queue depth between front and back end
    localparam int FIFO_DEPTH_DEF = 2;

    // Longest body sequence for one unit: backslash, U, plus, four hex digits
    localparam int BODY_MAX = 7;
    localparam int BODY_IW  = $clog2(BODY_MAX);

    // Special code units
    localparam logic [15:0] U_LF     = 16'h000A;
    localparam logic [15:0] U_CR     = 16'h000D;
    localparam logic [15:0] U_TAB    = 16'h0009;
    localparam logic [15:0] U_BSLASH = 16'h005C;
    localparam logic [15:0] U_QUOTE  = 16'h0022;
    localparam logic [15:0] U_COPY   = 16'h00A9;
    localparam logic [15:0] U_REG    = 16'h00AE;
    localparam logic [15:0] U_ENDASH = 16'h2013;
    localparam logic [15:0] U_RSQUO  = 16'h2019;
    localparam logic [15:0] U_TRADE  = 16'h2122;

    // Output characters
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_U      = 8'h55;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    // Channel payloads
    typedef struct packed {
        logic [15:0] code_unit;
        logic        first_unit;
        logic        last_unit;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_run;
    } out_item_t;

    // Classified unit handed from front to back end
    typedef logic [BODY_MAX-1:0][7:0] body_t;

    typedef struct packed {
        logic               pre_lead;   // indent and quote before the body
        logic               post_lead;  // line break, indent and quote after body
        logic               close;      // closing quote after the body
        logic [BODY_IW-1:0] body_len;   // 1 .. BODY_MAX
        body_t              body;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef struct packed {
        logic busy;
        logic last_byte;
    } back_status_t;

    // Back end sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SP,
        PH_QT,
        PH_BODY,
        PH_BR,
        PH_CLOSE
    } phase_t;

    // Uppercase hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'd0, nib};
        end else begin
            ch = 8'h37 + {4'd0, nib};
        end
        return ch;
    endfunction

endpackage

>>> hdl/ute_fifo.sv
// ----------------------------------------------------------------------------
// ute_fifo
// Small descriptor queue that decouples classification from byte output.
// ----------------------------------------------------------------------------
module ute_fifo #(
    parameter int DEPTH = ute_pkg::FIFO_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  ute_pkg::desc_t               push_data,
    input  logic                         pop,
    output ute_pkg::desc_t               head,
    output ute_pkg::fifo_status_t        status,
    output logic [$clog2(DEPTH+1)-1:0]   count
);
    import ute_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    desc_t           mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign do_push = push && (count_reg != CW'(DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    // Advance pointers with wrap at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign count        = count_reg;

endmodule

>>> hdl/ute_front.sv
// ----------------------------------------------------------------------------
// ute_front
// Accepts code units and classifies each into a byte descriptor.
// ----------------------------------------------------------------------------
module ute_front (
    input  ute_pkg::in_item_t      s_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   output_utf8,
    input  ute_pkg::fifo_status_t  q_status,
    output logic                   push,
    output ute_pkg::desc_t         desc
);
    import ute_pkg::*;

    logic [15:0] u;
    logic        is_lf;

    assign u       = s_data.code_unit;
    assign is_lf   = (u == U_LF);
    assign s_ready = !q_status.full;
    assign push    = s_valid && !q_status.full;

    // Classify the unit: framing flags and the body bytes
    always_comb begin
        desc.pre_lead  = s_data.first_unit;
        desc.post_lead = is_lf && !s_data.last_unit;
        desc.close     = s_data.last_unit && !is_lf;
        desc.body_len  = BODY_IW'(1);
        desc.body      = '0;
        priority if (is_lf) begin
            desc.body[0]  = CH_BSLASH;
            desc.body[1]  = CH_N;
            desc.body[2]  = CH_QUOTE;
            desc.body_len = BODY_IW'(3);
        end else if (u == U_CR) begin
            desc.body[0]  = CH_BSLASH;
            desc.body[1]  = CH_R;
            desc.body_len = BODY_IW'(2);
        end else if (u == U_TAB) begin
            desc.body[0]  = CH_BSLASH;
            desc.body[1]  = CH_T;
            desc.body_len = BODY_IW'(2);
        end else if (u == U_BSLASH) begin
            desc.body[0]  = CH_BSLASH;
            desc.body[1]  = CH_BSLASH;
            desc.body_len = BODY_IW'(2);
        end else if (u == U_QUOTE) begin
            desc.body[0]  = CH_BSLASH;
            desc.body[1]  = CH_QUOTE;
            desc.body_len = BODY_IW'(2);
        end else if (u < 16'h0080) begin
            desc.body[0]  = u[7:0];
        end else if (output_utf8) begin
            // Encode as two or three UTF-8 bytes, surrogates included
            if (u < 16'h0800) begin
                desc.body[0]  = {3'b110, u[10:6]};
                desc.body[1]  = {2'b10, u[5:0]};
                desc.body_len = BODY_IW'(2);
            end else begin
                desc.body[0]  = {4'b1110, u[15:12]};
                desc.body[1]  = {2'b10, u[11:6]};
                desc.body[2]  = {2'b10, u[5:0]};
                desc.body_len = BODY_IW'(3);
            end
        end else if (u == U_COPY) begin
            desc.body[0]  = CH_LPAREN;
            desc.body[1]  = CH_C;
            desc.body[2]  = CH_RPAREN;
            desc.body_len = BODY_IW'(3);
        end else if (u == U_REG) begin
            desc.body[0]  = CH_LPAREN;
            desc.body[1]  = CH_R;
            desc.body[2]  = CH_RPAREN;
            desc.body_len = BODY_IW'(3);
        end else if (u == U_ENDASH) begin
            desc.body[0]  = CH_DASH;
            desc.body[1]  = CH_DASH;
            desc.body_len = BODY_IW'(2);
        end else if (u == U_RSQUO) begin
            desc.body[0]  = CH_APOS;
        end else if (u == U_TRADE) begin
            desc.body[0]  = CH_LPAREN;
            desc.body[1]  = CH_T;
            desc.body[2]  = CH_M;
            desc.body[3]  = CH_RPAREN;
            desc.body_len = BODY_IW'(4);
        end else begin
            // Hex escape with four uppercase digits
            desc.body[0]  = CH_BSLASH;
            desc.body[1]  = CH_U;
            desc.body[2]  = CH_PLUS;
            desc.body[3]  = hex_char(u[15:12]);
            desc.body[4]  = hex_char(u[11:8]);
            desc.body[5]  = hex_char(u[7:4]);
            desc.body[6]  = hex_char(u[3:0]);
            desc.body_len = BODY_IW'(7);
        end
    end

endmodule

>>> hdl/ute_back.sv
// ----------------------------------------------------------------------------
// ute_back
// Walks each descriptor and emits its bytes into the output register, one
// per cycle unless m_ready stalls the output.
// ----------------------------------------------------------------------------
module ute_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [3:0]             indent_spaces,
    input  ute_pkg::desc_t         q_head,
    input  ute_pkg::fifo_status_t  q_status,
    output logic                   pop,
    output ute_pkg::back_status_t  status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output ute_pkg::out_item_t     m_data
);
    import ute_pkg::*;

    phase_t       phase_reg, phase_next;
    logic [3:0]   cnt_reg, cnt_next;
    logic         tail_reg, tail_next;
    desc_t        cur_reg, cur_next;
    logic         m_valid_reg, m_valid_next;
    out_item_t    m_data_reg;

    logic         busy, advance, body_end;
    logic [7:0]   byte_val;
    logic         byte_last;
    phase_t       start_phase;

    assign busy        = (phase_reg != PH_IDLE);
    assign advance     = busy && (!m_valid_reg || m_ready);
    assign body_end    = (cnt_reg[BODY_IW-1:0] == cur_reg.body_len - BODY_IW'(1));
    assign pop         = !q_status.empty && (!busy || (advance && byte_last));
    assign start_phase = !q_head.pre_lead          ? PH_BODY :
                         (indent_spaces == 4'd0)   ? PH_QT   : PH_SP;

    // Next state of the byte sequencer
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        tail_next  = tail_reg;
        cur_next   = cur_reg;
        if (pop) begin
            cur_next   = q_head;
            phase_next = start_phase;
            cnt_next   = '0;
            tail_next  = 1'b0;
        end else if (advance) begin
            unique case (phase_reg)
                PH_SP: begin
                    if (cnt_reg == indent_spaces - 4'd1) begin
                        phase_next = PH_QT;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
                PH_QT: begin
                    phase_next = tail_reg ? PH_IDLE : PH_BODY;
                    cnt_next   = '0;
                end
                PH_BODY: begin
                    if (body_end) begin
                        cnt_next = '0;
                        priority if (cur_reg.post_lead) begin
                            phase_next = PH_BR;
                        end else if (cur_reg.close) begin
                            phase_next = PH_CLOSE;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end else begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
                PH_BR: begin
                    tail_next  = 1'b1;
                    cnt_next   = '0;
                    phase_next = (indent_spaces == 4'd0) ? PH_QT : PH_SP;
                end
                PH_CLOSE: begin
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Byte and end marker for the current phase
    always_comb begin
        byte_val  = 8'h00;
        byte_last = 1'b0;
        unique case (phase_reg)
            PH_SP: begin
                byte_val = CH_SPACE;
            end
            PH_QT: begin
                byte_val  = CH_QUOTE;
                byte_last = tail_reg;
            end
            PH_BODY: begin
                byte_val  = cur_reg.body[cnt_reg[BODY_IW-1:0]];
                byte_last = body_end && !cur_reg.post_lead && !cur_reg.close;
            end
            PH_BR: begin
                byte_val = CH_LF;
            end
            PH_CLOSE: begin
                byte_val  = CH_QUOTE;
                byte_last = 1'b1;
            end
            default: begin
                byte_val  = 8'h00;
                byte_last = 1'b0;
            end
        endcase
    end

    // Load the output register on advance, drop valid once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            tail_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold descriptor and output payload
    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (advance) begin
            m_data_reg.out_byte   <= byte_val;
            m_data_reg.end_of_run <= byte_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_data           = m_data_reg;
    assign status.busy      = busy;
    assign status.last_byte = byte_last;

endmodule

>>> hdl/utf16be_to_utf8_escaper.sv
// ----------------------------------------------------------------------------
// utf16be_to_utf8_escaper
// Turns a string of UTF-16 code units into quoted, escaped UTF-8 or ASCII.
//
//   Channel   Ports               Direction   Item
//   input     s_valid/s_ready     in          one code unit with framing flags
//   output    m_valid/m_ready     out         one byte of escaped text
//   config    cfg_wr_en           in          register write, no handshake
//
// The output register emits one byte per cycle unless m_ready stalls it, and
// a unit produces 1 to 36 bytes. The front end takes one unit per cycle
// while the descriptor queue has room. Reset is synchronous; it empties the
// queue and the output register and restores the register defaults. Either
// side may stall independently; the queue absorbs the difference.
// ----------------------------------------------------------------------------
`include "utf16be_to_utf8_escaper_macros.svh"

module utf16be_to_utf8_escaper #(
    parameter int FIFO_DEPTH = ute_pkg::FIFO_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  ute_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output ute_pkg::out_item_t               m_data,
    input  logic                             cfg_wr_en,
    input  logic [ute_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ute_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import ute_pkg::*;

    localparam int CW = $clog2(FIFO_DEPTH+1);

    logic          output_utf8_reg;
    logic [3:0]    indent_reg;
    logic          push, pop;
    desc_t         front_desc, q_head;
    fifo_status_t  q_status;
    back_status_t  back_status;
    logic [CW-1:0] q_count;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_utf8_reg <= 1'b0;
            indent_reg      <= INDENT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_OUTPUT_UTF8) begin
                output_utf8_reg <= cfg_wdata[0];
            end
            if (cfg_index == REG_INDENT_SPACES) begin
                indent_reg <= cfg_wdata[3:0];
            end
        end
    end

    ute_front u_front (
        .s_data      (s_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .output_utf8 (output_utf8_reg),
        .q_status    (q_status),
        .push        (push),
        .desc        (front_desc)
    );

    ute_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_desc),
        .pop       (pop),
        .head      (q_head),
        .status    (q_status),
        .count     (q_count)
    );

    ute_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .indent_spaces (indent_reg),
        .q_head        (q_head),
        .q_status      (q_status),
        .pop           (pop),
        .status        (back_status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

    // An idle back end with queued work starts on it in the next cycle
    `ASSERT_NEXT(a_idle_starts, aclk, aresetn, !back_status.busy && !q_status.empty, back_status.busy)
    // An empty queue always leaves the input open
    `ASSERT_IMPLIES(a_empty_ready, aclk, aresetn, q_status.empty, s_ready)
    // Queue occupancy stays within its depth
    `ASSERT_NEVER(a_count_range, aclk, aresetn, q_count > CW'(FIFO_DEPTH))
    // A byte marked last never leaves the sequencer busy on the same unit
    `ASSERT_NEXT(a_last_ends_unit, aclk, aresetn, back_status.busy && back_status.last_byte && m_valid && m_ready && q_status.empty, !back_status.busy)

endmodule
